// ----- rtl/bapd_pkg.sv -----
// ----------------------------------------------------------------------------
// bapd_pkg
// Shared types and constants of the box average plane decimator.
// ----------------------------------------------------------------------------
package bapd_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int FACTOR_W  = 4;
    localparam int SIZE_W    = 11;
    localparam int ROW_W     = 10;
    localparam int CNT_W     = 3;
    localparam int SUM_W     = 16;
    localparam int RECIP_W   = 23;
    localparam int RECIP_SH  = 22;
    localparam int DIV_IDX_W = 6;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 4'd8;
    localparam logic [SIZE_W-1:0]   HEIGHT_LIMIT = 11'd1024;

    localparam logic [FACTOR_W-1:0] X_FACTOR_RST   = 4'd2;
    localparam logic [FACTOR_W-1:0] Y_FACTOR_RST   = 4'd2;
    localparam logic [SIZE_W-1:0]   OUT_WIDTH_RST  = 11'd360;
    localparam logic [SIZE_W-1:0]   OUT_HEIGHT_RST = 11'd288;

    typedef enum logic [1:0] {
        CFG_X_FACTOR   = 2'd0,
        CFG_Y_FACTOR   = 2'd1,
        CFG_OUT_WIDTH  = 2'd2,
        CFG_OUT_HEIGHT = 2'd3
    } t_cfg_index;

    // ceil(2^22 / d) for d = 1 .. 64, indexed by d - 1
    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:63] = '{
        23'd4194304, 23'd2097152, 23'd1398102, 23'd1048576,
        23'd838861,  23'd699051,  23'd599187,  23'd524288,
        23'd466034,  23'd419431,  23'd381301,  23'd349526,
        23'd322639,  23'd299594,  23'd279621,  23'd262144,
        23'd246724,  23'd233017,  23'd220753,  23'd209716,
        23'd199729,  23'd190651,  23'd182362,  23'd174763,
        23'd167773,  23'd161320,  23'd155345,  23'd149797,
        23'd144632,  23'd139811,  23'd135301,  23'd131072,
        23'd127101,  23'd123362,  23'd119838,  23'd116509,
        23'd113360,  23'd110377,  23'd107547,  23'd104858,
        23'd102301,  23'd99865,   23'd97542,   23'd95326,
        23'd93207,   23'd91181,   23'd89241,   23'd87382,
        23'd85599,   23'd83887,   23'd82242,   23'd80660,
        23'd79138,   23'd77673,   23'd76261,   23'd74899,
        23'd73585,   23'd72316,   23'd71090,   23'd69906,
        23'd68760,   23'd67651,   23'd66577,   23'd65536
    };

    typedef struct packed {
        logic accept;
        logic acc;
        logic mul;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic has_result;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/bapd_ram.sv -----
// ----------------------------------------------------------------------------
// bapd_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bapd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bapd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bapd_ctrl
// Sequencer: accept, accumulate and, when a box completes, scale and hand off the result.
// ----------------------------------------------------------------------------
module bapd_ctrl
    import bapd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.has_result ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ----- rtl/bapd_dp.sv -----
// ----------------------------------------------------------------------------
// bapd_dp
// Datapath: settings, block counters, column sum buffer, reciprocal scaling
// and output register.
// ----------------------------------------------------------------------------
module bapd_dp
    import bapd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SAMPLE_W-1:0] o_average,
    output logic                o_frame_end
);

    localparam int AW = $clog2(MAX_OUT_WIDTH);
    localparam int WW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_OUT_WIDTH);

    logic [FACTOR_W-1:0] r_x_factor;
    logic [FACTOR_W-1:0] r_y_factor;
    logic [SIZE_W-1:0]   r_out_width;
    logic [SIZE_W-1:0]   r_out_height;

    logic [FACTOR_W-1:0] xf;
    logic [FACTOR_W-1:0] yf;
    logic [WW-1:0]       w_ext;
    logic [WW-1:0]       w_lim;
    logic [SIZE_W-1:0]   h_lim;
    logic [2*FACTOR_W-1:0] area;

    logic [RECIP_W-1:0]   r_recip;

    logic [CNT_W-1:0]    r_pix;
    logic [CNT_W-1:0]    r_rib;
    logic [AW-1:0]       r_col;
    logic [ROW_W-1:0]    r_row;

    logic [SAMPLE_W-1:0] r_sample;
    logic [SUM_W-1:0]    r_sum;
    logic                r_frame_end;
    logic [PROD_W-1:0]   r_prod;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_average;
    logic                r_out_last;

    logic [SUM_W-1:0]    ram_rdata;
    logic [SUM_W-1:0]    sum;
    logic                first;
    logic                last_pixel;
    logic                last_row;
    logic                last_col;
    logic                last_orow;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_factor   <= X_FACTOR_RST;
            r_y_factor   <= Y_FACTOR_RST;
            r_out_width  <= OUT_WIDTH_RST;
            r_out_height <= OUT_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_X_FACTOR:   r_x_factor   <= i_cfg_data[FACTOR_W-1:0];
                CFG_Y_FACTOR:   r_y_factor   <= i_cfg_data[FACTOR_W-1:0];
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped settings
    always_comb begin
        xf = r_x_factor;
        if (r_x_factor == '0) begin
            xf = FACTOR_W'(1);
        end else if (r_x_factor > FACTOR_MAX) begin
            xf = FACTOR_MAX;
        end
        yf = r_y_factor;
        if (r_y_factor == '0) begin
            yf = FACTOR_W'(1);
        end else if (r_y_factor > FACTOR_MAX) begin
            yf = FACTOR_MAX;
        end
        w_ext = WW'(r_out_width);
        w_lim = w_ext;
        if (w_ext == '0) begin
            w_lim = WW'(1);
        end else if (w_ext > W_MAX) begin
            w_lim = W_MAX;
        end
        h_lim = r_out_height;
        if (r_out_height == '0) begin
            h_lim = SIZE_W'(1);
        end else if (r_out_height > HEIGHT_LIMIT) begin
            h_lim = HEIGHT_LIMIT;
        end
    end

    assign area = xf * yf;

    // reciprocal of the box area, settles while idle
    always_ff @(posedge i_clk) begin
        r_recip <= RECIP_TABLE[DIV_IDX_W'(area - 8'd1)];
    end

    bapd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_col_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc),
        .i_waddr (r_col),
        .i_wdata (sum),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        first      = (r_pix == '0) && (r_rib == '0);
        sum        = first ? SUM_W'(r_sample) : ram_rdata + SUM_W'(r_sample);
        last_pixel = ({1'b0, r_pix} + 4'd1) >= xf;
        last_row   = ({1'b0, r_rib} + 4'd1) >= yf;
        last_col   = (WW'(r_col) + WW'(1)) >= w_lim;
        last_orow  = ({1'b0, r_row} + 11'd1) >= h_lim;
    end

    // block counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
            r_rib <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.acc) begin
            if (!last_pixel) begin
                r_pix <= r_pix + 3'd1;
            end else begin
                r_pix <= '0;
                if (!last_col) begin
                    r_col <= r_col + AW'(1);
                end else begin
                    r_col <= '0;
                    if (!last_row) begin
                        r_rib <= r_rib + 3'd1;
                    end else begin
                        r_rib <= '0;
                        r_row <= last_orow ? '0 : r_row + ROW_W'(1);
                    end
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.acc) begin
            r_sum       <= sum;
            r_frame_end <= last_col && last_orow;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(r_recip);
        end
        if (i_cmd.load) begin
            r_average  <= r_prod[RECIP_SH +: SAMPLE_W];
            r_out_last <= r_frame_end;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.has_result = last_pixel && last_row;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_average           = r_average;
    assign o_frame_end         = r_out_last;

endmodule

// ----- rtl/box_average_plane_decimator_unit.sv -----
// ----------------------------------------------------------------------------
// box_average_plane_decimator_unit
// result path: sample, sum, product and output registers, in that order
// flow: buffer read-modify-write per sample, then reciprocal multiply when it
//   completes a box, waiting while the output stalls; one sample at a time
// reset: synchronous active low, counters cleared, settings to 2, 2, 360, 288
// ----------------------------------------------------------------------------
module box_average_plane_decimator_unit
    import bapd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [7:0] sample
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [7:0] average
    output logic                m_axis_tlast    // frame_end
);

    t_dp_cmd    cmd;
    t_dp_status status;

    bapd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bapd_dp #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_average   (m_axis_tdata),
        .o_frame_end (m_axis_tlast)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/bapd_checker.sv -----
// ----------------------------------------------------------------------------
// bapd_assertions
// Port-level checks of the box average plane decimator.
// ----------------------------------------------------------------------------
module bapd_assertions
    import bapd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_cfg_ready,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [SAMPLE_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in flight");

    // a new result only after the accumulate and scale steps
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready, 1) && !$past(s_axis_tready, 2))
        else $error("result appeared without accumulate and scale steps");

    // settings port ready whenever a sample is offered
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid |-> o_cfg_ready)
        else $error("config port not ready");

endmodule

bind box_average_plane_decimator_unit bapd_assertions u_bapd_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
